[hdl/hsv_to_rgb_converter_assert.svh]
// ----------------------------------------------------------------------------
// HSV to RGB converter assertion macros
// Concurrent assertion wrappers, empty when the design is synthesized.
// ----------------------------------------------------------------------------
`ifndef HSV_TO_RGB_CONVERTER_ASSERT_SVH
`define HSV_TO_RGB_CONVERTER_ASSERT_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define HSVC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hsvc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define HSVC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hsvc assertion failed");

`else

`define HSVC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define HSVC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[hdl/hsvc_pkg.sv]
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Widths, fixed-point constants and shared types of the converter.
// ----------------------------------------------------------------------------
package hsvc_pkg;

    localparam int COLOR_BITS        = 8;
    localparam int HUE_FRACTION_BITS = 6;

    localparam int HUE_BITS    = 9 + HUE_FRACTION_BITS;
    localparam int COLOR_MAX   = (1 << COLOR_BITS) - 1;
    localparam int SECTOR_SPAN = 60 << HUE_FRACTION_BITS;

    // Number of whole sectors that fit below the largest hue code.
    localparam int SECTOR_STEPS = ((1 << HUE_BITS) - 1) / SECTOR_SPAN;

    localparam int OFFS_BITS = $clog2(SECTOR_SPAN);
    localparam int D_BITS    = $clog2(SECTOR_SPAN + 1);
    localparam int SV_BITS   = 2 * COLOR_BITS;
    localparam int PROD_BITS = COLOR_BITS + D_BITS;

    // One sector is 15 << (HUE_FRACTION_BITS + 2): divide by the power of two
    // with a shift, then by 15 with a reciprocal multiply.
    localparam int SECT_SHIFT   = HUE_FRACTION_BITS + 2;
    localparam int SECTOR_DIV   = SECTOR_SPAN >> SECT_SHIFT;
    localparam int PQ_BITS      = PROD_BITS - SECT_SHIFT;
    localparam int RECIP_SHIFT  = PQ_BITS + 4;
    localparam int RECIP_MULT   = ((1 << RECIP_SHIFT) + SECTOR_DIV - 1) / SECTOR_DIV;
    localparam int RM_BITS      = PQ_BITS + RECIP_SHIFT;

    localparam int NUM_STAGES = 5;

    typedef logic [2:0] sector_t;

    // 60-degree hue sectors.
    localparam sector_t SEC_RY = 3'd0;
    localparam sector_t SEC_YG = 3'd1;
    localparam sector_t SEC_GC = 3'd2;
    localparam sector_t SEC_CB = 3'd3;
    localparam sector_t SEC_BM = 3'd4;
    localparam sector_t SEC_MR = 3'd5;

    // Load strobes of the pipeline stages.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } stage_en_t;

endpackage

[hdl/hsvc_in_if.sv]
// ----------------------------------------------------------------------------
// HSV pixel channel
// Valid/ready channel that carries one pixel as hue, saturation, brightness.
// ----------------------------------------------------------------------------
interface hsvc_in_if;

    logic                             valid;
    logic                             ready;
    logic [hsvc_pkg::HUE_BITS-1:0]    hue;
    logic [hsvc_pkg::COLOR_BITS-1:0]  saturation;
    logic [hsvc_pkg::COLOR_BITS-1:0]  brightness;

    modport source (output valid, output hue, output saturation, output brightness,
                    input ready);
    modport sink   (input valid, input hue, input saturation, input brightness,
                    output ready);

endinterface

[hdl/hsvc_out_if.sv]
// ----------------------------------------------------------------------------
// RGB pixel channel
// Valid/ready channel that carries one pixel as red, green, blue.
// ----------------------------------------------------------------------------
interface hsvc_out_if;

    logic                             valid;
    logic                             ready;
    logic [hsvc_pkg::COLOR_BITS-1:0]  red;
    logic [hsvc_pkg::COLOR_BITS-1:0]  green;
    logic [hsvc_pkg::COLOR_BITS-1:0]  blue;

    modport source (output valid, output red, output green, output blue,
                    input ready);
    modport sink   (input valid, input red, input green, input blue,
                    output ready);

endinterface

[hdl/hsvc_datapath.sv]
// ----------------------------------------------------------------------------
// HSV to RGB datapath
// Five register stages: sector split, chroma, chroma times offset, divide by
// the sector span, channel placement.
// ----------------------------------------------------------------------------
module hsvc_datapath (
    input  logic                             clk,
    input  hsvc_pkg::stage_en_t              en,
    input  logic [hsvc_pkg::HUE_BITS-1:0]    hue,
    input  logic [hsvc_pkg::COLOR_BITS-1:0]  saturation,
    input  logic [hsvc_pkg::COLOR_BITS-1:0]  brightness,
    output logic [hsvc_pkg::COLOR_BITS-1:0]  red,
    output logic [hsvc_pkg::COLOR_BITS-1:0]  green,
    output logic [hsvc_pkg::COLOR_BITS-1:0]  blue
);

    // Stage 1: sector, offset, s*v.
    hsvc_pkg::sector_t                   sec_walk;
    logic [hsvc_pkg::HUE_BITS-1:0]       offs_full;
    hsvc_pkg::sector_t                   sec1_next, sec1_reg;
    logic [hsvc_pkg::OFFS_BITS-1:0]      offs1_next, offs1_reg;
    logic [hsvc_pkg::SV_BITS-1:0]        sv1_next, sv1_reg;
    logic [hsvc_pkg::COLOR_BITS-1:0]     val1_reg;

    // Stage 2: chroma and distance into the sector.
    logic [hsvc_pkg::SV_BITS-1:0]        cnum;
    logic [hsvc_pkg::SV_BITS:0]          cq;
    logic [hsvc_pkg::COLOR_BITS-1:0]     c2_next, c2_reg;
    logic [hsvc_pkg::D_BITS-1:0]         d2_next, d2_reg;
    hsvc_pkg::sector_t                   sec2_reg;
    logic [hsvc_pkg::COLOR_BITS-1:0]     val2_reg;

    // Stage 3: rounded product c*d and the floor level m.
    logic [hsvc_pkg::PROD_BITS-1:0]      prod3_next, prod3_reg;
    logic [hsvc_pkg::COLOR_BITS-1:0]     m3_next, m3_reg;
    logic [hsvc_pkg::COLOR_BITS-1:0]     c3_reg;
    hsvc_pkg::sector_t                   sec3_reg;

    // Stage 4: reciprocal multiply for the division by 15.
    logic [hsvc_pkg::PQ_BITS-1:0]        quo_in;
    logic [hsvc_pkg::RM_BITS-1:0]        mul4_next, mul4_reg;
    logic [hsvc_pkg::COLOR_BITS-1:0]     m4_reg;
    logic [hsvc_pkg::COLOR_BITS-1:0]     c4_reg;
    hsvc_pkg::sector_t                   sec4_reg;

    // Stage 5: placement into the channels.
    logic [hsvc_pkg::COLOR_BITS-1:0]     x5;
    logic [hsvc_pkg::COLOR_BITS-1:0]     r5, g5, b5;
    logic [hsvc_pkg::COLOR_BITS-1:0]     red5_next, red5_reg;
    logic [hsvc_pkg::COLOR_BITS-1:0]     green5_next, green5_reg;
    logic [hsvc_pkg::COLOR_BITS-1:0]     blue5_next, blue5_reg;

    // Compare the raw hue against every whole number of sectors. Counting the
    // sector modulo six folds the wrap past a full turn into the same step.
    always_comb
    begin
        sec_walk  = hsvc_pkg::SEC_RY;
        sec1_next = hsvc_pkg::SEC_RY;
        offs_full = hue;
        for (int k = 1; k <= hsvc_pkg::SECTOR_STEPS; k++)
        begin
            sec_walk = (sec_walk == hsvc_pkg::SEC_MR) ? hsvc_pkg::SEC_RY
                                                      : sec_walk + 3'd1;
            if (hue >= hsvc_pkg::HUE_BITS'(k * hsvc_pkg::SECTOR_SPAN))
            begin
                sec1_next = sec_walk;
                offs_full = hue - hsvc_pkg::HUE_BITS'(k * hsvc_pkg::SECTOR_SPAN);
            end
        end
    end

    assign offs1_next = offs_full[hsvc_pkg::OFFS_BITS-1:0];
    assign sv1_next   = hsvc_pkg::SV_BITS'(saturation) * hsvc_pkg::SV_BITS'(brightness);

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            sec1_reg  <= sec1_next;
            offs1_reg <= offs1_next;
            sv1_reg   <= sv1_next;
            val1_reg  <= brightness;
        end
    end

    // Division by 2^k-1 for a numerator below 2^(2k): (n + (n >> k) + 1) >> k.
    assign cnum = sv1_reg + hsvc_pkg::SV_BITS'(hsvc_pkg::COLOR_MAX >> 1);
    assign cq   = (hsvc_pkg::SV_BITS + 1)'(cnum)
                + (hsvc_pkg::SV_BITS + 1)'(cnum >> hsvc_pkg::COLOR_BITS)
                + (hsvc_pkg::SV_BITS + 1)'(1);
    assign c2_next = cq[hsvc_pkg::COLOR_BITS +: hsvc_pkg::COLOR_BITS];
    assign d2_next = sec1_reg[0]
                   ? hsvc_pkg::D_BITS'(hsvc_pkg::SECTOR_SPAN) - hsvc_pkg::D_BITS'(offs1_reg)
                   : hsvc_pkg::D_BITS'(offs1_reg);

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            c2_reg   <= c2_next;
            d2_reg   <= d2_next;
            sec2_reg <= sec1_reg;
            val2_reg <= val1_reg;
        end
    end

    assign prod3_next = hsvc_pkg::PROD_BITS'(c2_reg) * hsvc_pkg::PROD_BITS'(d2_reg)
                      + hsvc_pkg::PROD_BITS'(hsvc_pkg::SECTOR_SPAN / 2);
    assign m3_next    = val2_reg - c2_reg;

    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            prod3_reg <= prod3_next;
            m3_reg    <= m3_next;
            c3_reg    <= c2_reg;
            sec3_reg  <= sec2_reg;
        end
    end

    assign quo_in    = prod3_reg[hsvc_pkg::PROD_BITS-1:hsvc_pkg::SECT_SHIFT];
    assign mul4_next = hsvc_pkg::RM_BITS'(quo_in)
                     * hsvc_pkg::RM_BITS'(hsvc_pkg::RECIP_MULT);

    always_ff @(posedge clk)
    begin
        if (en.s4)
        begin
            mul4_reg <= mul4_next;
            m4_reg   <= m3_reg;
            c4_reg   <= c3_reg;
            sec4_reg <= sec3_reg;
        end
    end

    assign x5 = mul4_reg[hsvc_pkg::RECIP_SHIFT +: hsvc_pkg::COLOR_BITS];

    always_comb
    begin
        unique case (sec4_reg)
            hsvc_pkg::SEC_RY:
            begin
                r5 = c4_reg; g5 = x5;     b5 = '0;
            end
            hsvc_pkg::SEC_YG:
            begin
                r5 = x5;     g5 = c4_reg; b5 = '0;
            end
            hsvc_pkg::SEC_GC:
            begin
                r5 = '0;     g5 = c4_reg; b5 = x5;
            end
            hsvc_pkg::SEC_CB:
            begin
                r5 = '0;     g5 = x5;     b5 = c4_reg;
            end
            hsvc_pkg::SEC_BM:
            begin
                r5 = x5;     g5 = '0;     b5 = c4_reg;
            end
            default:
            begin
                r5 = c4_reg; g5 = '0;     b5 = x5;
            end
        endcase
    end

    assign red5_next   = r5 + m4_reg;
    assign green5_next = g5 + m4_reg;
    assign blue5_next  = b5 + m4_reg;

    always_ff @(posedge clk)
    begin
        if (en.s5)
        begin
            red5_reg   <= red5_next;
            green5_reg <= green5_next;
            blue5_reg  <= blue5_next;
        end
    end

    assign red   = red5_reg;
    assign green = green5_reg;
    assign blue  = blue5_reg;

endmodule

[hdl/hsv_to_rgb_converter.sv]
// ----------------------------------------------------------------------------
// HSV to RGB converter
// Converts a stream of pixels from hue, saturation, value to red, green, blue.
// ----------------------------------------------------------------------------
// The converter takes one pixel per clock cycle while its input is not held
// off and returns its color in order, one result per pixel, through the five
// register stages of the datapath; each stage holds its item
// only while the stage after it is full and stalled, so an empty stage always
// takes a new item and the input is held off only when all five are full and
// the output is not taken. Hue is in 1/64 degree, 0 to 23039; codes from
// 23040 up are wrapped by one full turn. All channels use 255 for 1.0.
// There is no configuration and no state beyond the pipeline.
`include "hsv_to_rgb_converter_assert.svh"

module hsv_to_rgb_converter (
    input logic       clk,
    input logic       rst_n,
    hsvc_in_if.sink   hsv,
    hsvc_out_if.source rgb
);

    logic [hsvc_pkg::NUM_STAGES-1:0] vld_reg, vld_next;
    logic [hsvc_pkg::NUM_STAGES-1:0] rdy;
    logic [hsvc_pkg::NUM_STAGES-1:0] load;
    hsvc_pkg::stage_en_t             en;
    logic                            in_fire;
    logic                            out_fire;

    // A stage takes a new item when it is empty or its item moves on.
    always_comb
    begin
        rdy[hsvc_pkg::NUM_STAGES-1] = !vld_reg[hsvc_pkg::NUM_STAGES-1] || rgb.ready;
        for (int i = hsvc_pkg::NUM_STAGES - 2; i >= 0; i--)
        begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end

        load[0]     = rdy[0] && hsv.valid;
        vld_next[0] = rdy[0] ? hsv.valid : vld_reg[0];
        for (int i = 1; i < hsvc_pkg::NUM_STAGES; i++)
        begin
            load[i]     = rdy[i] && vld_reg[i-1];
            vld_next[i] = rdy[i] ? vld_reg[i-1] : vld_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign en.s1 = load[0];
    assign en.s2 = load[1];
    assign en.s3 = load[2];
    assign en.s4 = load[3];
    assign en.s5 = load[4];

    hsvc_datapath u_datapath (
        .clk        (clk),
        .en         (en),
        .hue        (hsv.hue),
        .saturation (hsv.saturation),
        .brightness (hsv.brightness),
        .red        (rgb.red),
        .green      (rgb.green),
        .blue       (rgb.blue)
    );

    assign hsv.ready = rdy[0];
    assign rgb.valid = vld_reg[hsvc_pkg::NUM_STAGES-1];

    assign in_fire  = hsv.valid && hsv.ready;
    assign out_fire = rgb.valid && rgb.ready;

    // Every input transfer lands in the first stage.
    `HSVC_ASSERT_NEXT(a_in_lands, clk, rst_n, in_fire, vld_reg[0])
    // The input is held off only when the whole pipeline is full and stalled.
    `HSVC_ASSERT_IMPLIES(a_full_stall, clk, rst_n, (&vld_reg) && !rgb.ready, !hsv.ready)
    `HSVC_ASSERT_IMPLIES(a_bubble_ready, clk, rst_n, !(&vld_reg), hsv.ready)
    // Items in flight change only by transfers at either end.
    `HSVC_ASSERT_NEXT(a_count, clk, rst_n, 1'b1, $countones(vld_reg) == $past($countones(vld_reg)) + $past(in_fire) - $past(out_fire))

endmodule

[test/hsv_to_rgb_converter_checker.sv]
// ----------------------------------------------------------------------------
// HSV to RGB converter checker
// Watches both pixel channels, predicts the color of every pixel taken in and
// compares it, channel by channel and in order, with the pixels given out.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_checker (
    input  logic       clk,
    input  logic       rst_n,
    hsvc_in_if         hsv,
    hsvc_out_if        rgb,
    output int         mismatches,
    output int         pending,
    output int         pixels_done,
    output int         wrapped_hues
);

    import hsvc_pkg::*;

    localparam int FULL_TURN = 6 * SECTOR_SPAN;

    typedef struct packed {
        logic [COLOR_BITS-1:0] red;
        logic [COLOR_BITS-1:0] green;
        logic [COLOR_BITS-1:0] blue;
    } rgb_pixel_t;

    rgb_pixel_t expected_colors[$];

    initial
    begin
        mismatches   = 0;
        pending      = 0;
        pixels_done  = 0;
        wrapped_hues = 0;
    end

    function automatic rgb_pixel_t convert_pixel(input logic [HUE_BITS-1:0]   hue,
                                                 input logic [COLOR_BITS-1:0] sat,
                                                 input logic [COLOR_BITS-1:0] val);
        int unsigned angle;
        int unsigned sector;
        int unsigned offs;
        int unsigned sector_dist;
        int unsigned chroma;
        int unsigned mid;
        int unsigned floor_level;
        int unsigned r;
        int unsigned g;
        int unsigned b;
        rgb_pixel_t  pixel;
        angle = int'(hue);
        // One full turn is taken off once; the field cannot hold two.
        if (angle >= FULL_TURN)
            angle = angle - FULL_TURN;
        sector = angle / SECTOR_SPAN;
        offs   = angle % SECTOR_SPAN;
        sector_dist = sector[0] ? SECTOR_SPAN - offs : offs;
        chroma = (int'(sat) * int'(val) + COLOR_MAX / 2) / COLOR_MAX;
        mid    = (chroma * sector_dist + SECTOR_SPAN / 2) / SECTOR_SPAN;
        floor_level = int'(val) - chroma;
        case (sector_t'(sector))
            SEC_RY:  begin r = chroma; g = mid;    b = 0;      end
            SEC_YG:  begin r = mid;    g = chroma; b = 0;      end
            SEC_GC:  begin r = 0;      g = chroma; b = mid;    end
            SEC_CB:  begin r = 0;      g = mid;    b = chroma; end
            SEC_BM:  begin r = mid;    g = 0;      b = chroma; end
            default: begin r = chroma; g = 0;      b = mid;    end
        endcase
        pixel.red   = COLOR_BITS'(r + floor_level);
        pixel.green = COLOR_BITS'(g + floor_level);
        pixel.blue  = COLOR_BITS'(b + floor_level);
        return pixel;
    endfunction

    task automatic check_channel(input string name, input logic [COLOR_BITS-1:0] want,
                                 input logic [COLOR_BITS-1:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatches = mismatches + 1;
        end
    endtask

    always @(posedge clk)
    begin : watch
        rgb_pixel_t want;
        if (rst_n)
        begin
            if (hsv.valid && hsv.ready)
            begin
                expected_colors.push_back(convert_pixel(hsv.hue, hsv.saturation,
                                                        hsv.brightness));
                if (hsv.hue >= FULL_TURN)
                    wrapped_hues = wrapped_hues + 1;
            end
            if (rgb.valid && rgb.ready)
            begin
                if (expected_colors.size() == 0)
                begin
                    $error("pixel out with no pixel in: red %0d green %0d blue %0d",
                           rgb.red, rgb.green, rgb.blue);
                    mismatches = mismatches + 1;
                end
                else
                begin
                    want = expected_colors.pop_front();
                    check_channel("red", want.red, rgb.red);
                    check_channel("green", want.green, rgb.green);
                    check_channel("blue", want.blue, rgb.blue);
                end
                pixels_done = pixels_done + 1;
            end
            pending = expected_colors.size();
        end
    end

endmodule

[test/hsv_to_rgb_converter_test.sv]
// ----------------------------------------------------------------------------
// HSV to RGB converter testbench
// Feeds directed corner pixels and a long random pixel stream with idle gaps
// on both channels, a long output stall and a drain pause; the checker beside
// the converter predicts every color and reports the mismatches.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_test;

    import hsvc_pkg::*;

    localparam int RANDOM_PIXELS   = 800;
    localparam int HOLD_OFF_CYCLES = 60;
    localparam int BURST_PIXELS    = 25;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int FULL_TURN       = 6 * SECTOR_SPAN;
    localparam int HUE_TOP         = (1 << HUE_BITS) - 1;

    logic clk = 1'b0;
    logic rst_n;
    logic steady = 1'b0;
    logic hold_off_req = 1'b0;
    int   mismatches;
    int   pending;
    int   pixels_done;
    int   wrapped_hues;
    int   quiet_cycles = 0;

    hsvc_in_if  hsv ();
    hsvc_out_if rgb ();

    hsv_to_rgb_converter dut (
        .clk   (clk),
        .rst_n (rst_n),
        .hsv   (hsv),
        .rgb   (rgb)
    );

    hsv_to_rgb_converter_checker checker_inst (
        .clk          (clk),
        .rst_n        (rst_n),
        .hsv          (hsv),
        .rgb          (rgb),
        .mismatches   (mismatches),
        .pending      (pending),
        .pixels_done  (pixels_done),
        .wrapped_hues (wrapped_hues)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int gap_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (steady || pick < 55)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [COLOR_BITS-1:0] pick_level();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 12)
            return '0;
        if (pick < 24)
            return COLOR_BITS'(COLOR_MAX);
        return COLOR_BITS'($urandom_range(0, COLOR_MAX));
    endfunction

    task automatic send_pixel(input logic [HUE_BITS-1:0]   hue,
                              input logic [COLOR_BITS-1:0] sat,
                              input logic [COLOR_BITS-1:0] val);
        hsv.valid      <= 1'b1;
        hsv.hue        <= hue;
        hsv.saturation <= sat;
        hsv.brightness <= val;
        @(posedge clk);
        while (!hsv.ready)
            @(posedge clk);
    endtask

    // Directed pixels are written as plain numbers and sized here.
    task automatic send_corner(input int hue, input int sat, input int val);
        send_pixel(HUE_BITS'(hue), COLOR_BITS'(sat), COLOR_BITS'(val));
    endtask

    task automatic idle_sender(input int cycles);
        if (cycles > 0)
        begin
            hsv.valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // The checker counts the transfer in flight at the next clock edge, so
    // the wait for an empty pipeline starts after that edge.
    task automatic drain();
        hsv.valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
    endtask

    task automatic send_random_pixel();
        logic [HUE_BITS-1:0] hue;
        int                  pick;
        pick = $urandom_range(0, 99);
        if (pick < 75)
            hue = HUE_BITS'($urandom_range(0, FULL_TURN - 1));
        else if (pick < 88)
            hue = HUE_BITS'($urandom_range(FULL_TURN, HUE_TOP));
        else
            hue = HUE_BITS'(SECTOR_SPAN * $urandom_range(1, 8) + $urandom_range(0, 2) - 1);
        send_pixel(hue, pick_level(), pick_level());
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((hsv.valid && hsv.ready) || (rgb.valid && rgb.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin : receiver
        int stall;
        rgb.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                rgb.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else
            begin
                stall = gap_len();
                if (stall > 0)
                begin
                    rgb.ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
                rgb.ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    initial
    begin : sender
        rst_n          <= 1'b0;
        hsv.valid      <= 1'b0;
        hsv.hue        <= '0;
        hsv.saturation <= '0;
        hsv.brightness <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Corners: sector edges, the wrap past one full turn, the largest
        // hue code, and the extremes of saturation and brightness.
        send_corner(0, 255, 255);                 idle_sender(gap_len());
        send_corner(SECTOR_SPAN - 1, 255, 255);   idle_sender(gap_len());
        send_corner(SECTOR_SPAN, 255, 255);       idle_sender(gap_len());
        send_corner(SECTOR_SPAN / 2, 255, 255);   idle_sender(gap_len());
        send_corner(2 * SECTOR_SPAN - 1, 200, 100); idle_sender(gap_len());
        send_corner(2 * SECTOR_SPAN, 128, 1);     idle_sender(gap_len());
        send_corner(3 * SECTOR_SPAN, 255, 128);   idle_sender(gap_len());
        send_corner(4 * SECTOR_SPAN + 1920, 90, 240); idle_sender(gap_len());
        send_corner(5 * SECTOR_SPAN, 255, 255);   idle_sender(gap_len());
        send_corner(FULL_TURN - 1, 255, 255);     idle_sender(gap_len());
        send_corner(FULL_TURN, 255, 255);         idle_sender(gap_len());
        send_corner(FULL_TURN + SECTOR_SPAN + 7, 170, 85); idle_sender(gap_len());
        send_corner(HUE_TOP, 255, 255);           idle_sender(gap_len());
        send_corner(HUE_TOP, 0, 0);               idle_sender(gap_len());
        send_corner(12345, 0, 255);               idle_sender(gap_len());
        send_corner(6789, 255, 0);                idle_sender(gap_len());
        send_corner(16384, 1, 254);               idle_sender(gap_len());
        send_corner(21000, 127, 127);
        drain();

        for (int i = 0; i < RANDOM_PIXELS; i++)
        begin
            if (i == 200)
            begin
                // Output held off while pixels keep coming: the pipeline
                // fills and must stall its input.
                hold_off_req = 1'b1;
                for (int k = 0; k < BURST_PIXELS; k++)
                    send_random_pixel();
            end
            if (i == 600)
                drain();
            steady = (i >= 400 && i < 500);
            send_random_pixel();
            idle_sender(gap_len());
        end
        steady = 1'b0;
        drain();
        repeat (NUM_STAGES + 4) @(posedge clk);

        $display("Converted %0d pixels through gaps, stalls and a full pipeline,",
                 pixels_done);
        $display("%0d of them with a hue code past one full turn.", wrapped_hues);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[hsv_to_rgb_converter.f]
+incdir+hdl
hdl/hsvc_pkg.sv
hdl/hsvc_in_if.sv
hdl/hsvc_out_if.sv
hdl/hsvc_datapath.sv
hdl/hsv_to_rgb_converter.sv
test/hsv_to_rgb_converter_checker.sv
test/hsv_to_rgb_converter_test.sv
